// ===== src/asp_pkg.sv =====
`timescale 1ns / 1ps

package asp_pkg;

  localparam int unsigned StackDepthDefault = 32;
  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned ValueOutWidth     = 32;
  localparam int unsigned CharWidth         = 8;

  localparam logic [CharWidth-1:0] CharPlus   = 8'h2B;
  localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] CharLParen = 8'h28;
  localparam logic [CharWidth-1:0] CharRParen = 8'h29;
  localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
  localparam logic [CharWidth-1:0] CharZero   = 8'h30;
  localparam logic [CharWidth-1:0] CharNine   = 8'h39;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusOverflow   = 2'd1,
    StatusUnbalanced = 2'd2,
    StatusInvalid    = 2'd3
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_cmd_t;

endpackage

// ===== src/asp_stack.sv =====
`timescale 1ns / 1ps

module asp_stack #(
  parameter int unsigned StackDepth = asp_pkg::StackDepthDefault,
  parameter int unsigned ValueWidth = asp_pkg::ValueWidthDefault,
  localparam int unsigned DepthW    = $clog2(StackDepth + 1),
  localparam int unsigned AddrW     = $clog2(StackDepth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  asp_pkg::stack_cmd_t   cmd_i,
  input  logic [ValueWidth-1:0] push_sum_i,
  input  logic                  push_neg_i,
  output logic [ValueWidth-1:0] top_sum_o,
  output logic                  top_neg_o,
  output logic [DepthW-1:0]     depth_o
);

  localparam int unsigned FrameW = ValueWidth + 1;

  // top frame lives in registers, frames below it in the memory;
  // rd_q always holds the frame just under the top
  logic [FrameW-1:0] mem [StackDepth];
  logic [FrameW-1:0] top_q, top_d;
  logic [FrameW-1:0] rd_q;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [DepthW-1:0] waddr_full, raddr_full;
  logic [AddrW-1:0]  waddr, raddr;
  logic              we;

  assign waddr_full = depth_q - DepthW'(1);
  assign raddr_full = depth_d - DepthW'(2);
  assign waddr      = waddr_full[AddrW-1:0];
  assign raddr      = raddr_full[AddrW-1:0];
  assign we         = cmd_i.push && (depth_q != '0);

  always_comb begin
    depth_d = depth_q;
    top_d   = top_q;
    if (cmd_i.push) begin
      depth_d = depth_q + DepthW'(1);
      top_d   = {push_neg_i, push_sum_i};
    end else if (cmd_i.pop) begin
      depth_d = depth_q - DepthW'(1);
      top_d   = rd_q;
    end
    if (cmd_i.clear) begin
      depth_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= top_q;
    end
    if (we && (waddr == raddr)) begin
      rd_q <= top_q;
    end else begin
      rd_q <= mem[raddr];
    end
  end

  assign top_sum_o = top_q[ValueWidth-1:0];
  assign top_neg_o = top_q[FrameW-1];
  assign depth_o   = depth_q;

endmodule

// ===== src/asp_step.sv =====
`timescale 1ns / 1ps

module asp_step #(
  parameter int unsigned StackDepth = asp_pkg::StackDepthDefault,
  parameter int unsigned ValueWidth = asp_pkg::ValueWidthDefault,
  localparam int unsigned DepthW    = $clog2(StackDepth + 1)
) (
  input  logic [asp_pkg::CharWidth-1:0] character_i,
  input  logic                          last_i,
  input  logic [ValueWidth-1:0]         accum_i,
  input  logic [ValueWidth-1:0]         sum_i,
  input  logic                          sign_i,
  input  asp_pkg::status_e              status_i,
  input  logic [DepthW-1:0]             depth_i,
  input  logic [ValueWidth-1:0]         top_sum_i,
  input  logic                          top_neg_i,
  output logic [ValueWidth-1:0]         accum_o,
  output logic [ValueWidth-1:0]         sum_o,
  output logic                          sign_o,
  output asp_pkg::status_e              status_o,
  output asp_pkg::stack_cmd_t           cmd_o,
  output logic [ValueWidth-1:0]         push_sum_o,
  output logic                          push_neg_o,
  output logic [ValueWidth-1:0]         result_value_o,
  output asp_pkg::status_e              result_status_o
);

  logic                  is_digit;
  logic [ValueWidth-1:0] digit;
  logic [ValueWidth-1:0] accum_mac;
  logic [ValueWidth-1:0] folded;
  logic [ValueWidth-1:0] tail_sum;
  logic                  need_fold;
  logic                  open_at_end;
  asp_pkg::status_e      err;
  asp_pkg::status_e      status_mid;

  assign is_digit  = (character_i >= asp_pkg::CharZero) && (character_i <= asp_pkg::CharNine);
  assign digit     = ValueWidth'(character_i[3:0]);
  assign accum_mac = (accum_i << 3) + (accum_i << 1) + digit;
  assign folded    = sign_i ? (sum_i - accum_i) : (sum_i + accum_i);

  always_comb begin
    accum_o     = accum_i;
    sum_o       = sum_i;
    sign_o      = sign_i;
    cmd_o       = '0;
    push_sum_o  = sum_i;
    push_neg_o  = sign_i;
    err         = asp_pkg::StatusOk;
    need_fold   = 1'b0;
    cmd_o.clear = last_i;
    priority if (is_digit) begin
      accum_o   = accum_mac;
      need_fold = 1'b1;
    end else if ((character_i == asp_pkg::CharPlus) ||
                 (character_i == asp_pkg::CharMinus)) begin
      sum_o   = folded;
      accum_o = '0;
      sign_o  = (character_i == asp_pkg::CharMinus);
    end else if (character_i == asp_pkg::CharLParen) begin
      if (depth_i < DepthW'(StackDepth)) begin
        cmd_o.push = 1'b1;
        sum_o      = '0;
        accum_o    = '0;
        sign_o     = 1'b0;
      end else begin
        err       = asp_pkg::StatusOverflow;
        need_fold = 1'b1;
      end
    end else if (character_i == asp_pkg::CharRParen) begin
      accum_o = '0;
      sign_o  = 1'b0;
      if (depth_i != '0) begin
        cmd_o.pop = 1'b1;
        sum_o     = top_neg_i ? (top_sum_i - folded) : (top_sum_i + folded);
      end else begin
        sum_o = folded;
        err   = asp_pkg::StatusUnbalanced;
      end
    end else if (character_i == asp_pkg::CharSpace) begin
      need_fold = 1'b1;
    end else begin
      err       = asp_pkg::StatusInvalid;
      need_fold = 1'b1;
    end
  end

  assign status_mid = (status_i != asp_pkg::StatusOk) ? status_i : err;
  assign status_o   = status_mid;

  always_comb begin
    priority if (cmd_o.push) begin
      open_at_end = 1'b1;
    end else if (cmd_o.pop) begin
      open_at_end = (depth_i != DepthW'(1));
    end else begin
      open_at_end = (depth_i != '0);
    end
  end

  // sum and sign are untouched whenever the number is still pending
  assign tail_sum       = sign_i ? (sum_i - accum_o) : (sum_i + accum_o);
  assign result_value_o = need_fold ? tail_sum : sum_o;
  assign result_status_o = ((status_mid == asp_pkg::StatusOk) && open_at_end) ?
                           asp_pkg::StatusUnbalanced : status_mid;

endmodule

// ===== src/add_sub_paren_expression_eval.sv =====
`timescale 1ns / 1ps

// Evaluates an infix expression of decimal numbers, unary and binary + and -,
// nested parentheses and spaces, fed as one ASCII character per item. One
// item is taken every clock cycle unless in_stall_o is high; the value and
// status of an expression appear on the output in the cycle after the item
// marked last is taken and are held until the output is no longer stalled.
// Only an item marked last waits on a stalled output; other items keep
// flowing. Parenthesis frames sit in an on-chip stack whose top frame is
// held in registers and whose next frame is read ahead every cycle.
// Status is the first error seen: stack overflow (the open parenthesis is
// dropped), unbalanced parentheses, or an invalid character (ignored).
// Sums wrap modulo 2^VALUE_WIDTH; value_o carries the low 32 bits.

module add_sub_paren_expression_eval #(
  parameter int unsigned STACK_DEPTH = asp_pkg::StackDepthDefault,
  parameter int unsigned VALUE_WIDTH = asp_pkg::ValueWidthDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [asp_pkg::CharWidth-1:0]           character_i,
  input  logic                                    last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [asp_pkg::ValueOutWidth-1:0] value_o,
  output logic [1:0]                              status_o
);

  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1);

  logic                    accept;
  logic [VALUE_WIDTH-1:0]  accum_q, accum_d;
  logic [VALUE_WIDTH-1:0]  sum_q, sum_d;
  logic                    sign_q, sign_d;
  asp_pkg::status_e        status_q, status_d;
  asp_pkg::stack_cmd_t     step_cmd, stack_cmd;
  logic [VALUE_WIDTH-1:0]  push_sum;
  logic                    push_neg;
  logic [VALUE_WIDTH-1:0]  top_sum;
  logic                    top_neg;
  logic [DepthW-1:0]       depth;
  logic [VALUE_WIDTH-1:0]  result_value;
  asp_pkg::status_e        result_status;
  logic                    out_valid_q;
  logic [asp_pkg::ValueOutWidth-1:0] value_q;
  asp_pkg::status_e        out_status_q;

  assign in_stall_o = out_valid_q && out_stall_i && last_i;
  assign accept     = in_valid_i && !in_stall_o;

  asp_step #(
    .StackDepth (STACK_DEPTH),
    .ValueWidth (VALUE_WIDTH)
  ) u_step (
    .character_i     (character_i),
    .last_i          (last_i),
    .accum_i         (accum_q),
    .sum_i           (sum_q),
    .sign_i          (sign_q),
    .status_i        (status_q),
    .depth_i         (depth),
    .top_sum_i       (top_sum),
    .top_neg_i       (top_neg),
    .accum_o         (accum_d),
    .sum_o           (sum_d),
    .sign_o          (sign_d),
    .status_o        (status_d),
    .cmd_o           (step_cmd),
    .push_sum_o      (push_sum),
    .push_neg_o      (push_neg),
    .result_value_o  (result_value),
    .result_status_o (result_status)
  );

  assign stack_cmd.push  = accept && step_cmd.push;
  assign stack_cmd.pop   = accept && step_cmd.pop;
  assign stack_cmd.clear = accept && step_cmd.clear;

  asp_stack #(
    .StackDepth (STACK_DEPTH),
    .ValueWidth (VALUE_WIDTH)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stack_cmd),
    .push_sum_i (push_sum),
    .push_neg_i (push_neg),
    .top_sum_o  (top_sum),
    .top_neg_o  (top_neg),
    .depth_o    (depth)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q  <= '0;
      sum_q    <= '0;
      sign_q   <= 1'b0;
      status_q <= asp_pkg::StatusOk;
    end else if (accept) begin
      if (last_i) begin
        accum_q  <= '0;
        sum_q    <= '0;
        sign_q   <= 1'b0;
        status_q <= asp_pkg::StatusOk;
      end else begin
        accum_q  <= accum_d;
        sum_q    <= sum_d;
        sign_q   <= sign_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      value_q      <= asp_pkg::ValueOutWidth'(result_value);
      out_status_q <= result_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = out_status_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FrameDepth = asp_pkg::StackDepthDefault;
  localparam int unsigned ItemTarget = 1300;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumDirRows = 12;

  typedef struct packed {
    logic [31:0]      value;
    asp_pkg::status_e status;
  } expr_result_t;

  typedef struct packed {
    logic         on;
    expr_result_t r;
  } pin_t;

  typedef struct {
    string            text;
    bit               lead_nul;
    int unsigned      opens;
    bit               pinned;
    logic [31:0]      value;
    asp_pkg::status_e status;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  character_i = 8'h00;
  logic        last_i      = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic signed [31:0] value_o;
  logic [1:0]  status_o;

  add_sub_paren_expression_eval i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .character_i,
    .last_i,
    .out_valid_o,
    .out_stall_i,
    .value_o,
    .status_o
  );

  // directed expressions; pinned rows carry a hand-written result
  dir_row_t dir_rows [NumDirRows] = '{
    '{"0",            1'b0, 0,  1'b1, 32'd0,        asp_pkg::StatusOk},
    '{" ",            1'b0, 0,  1'b1, 32'd0,        asp_pkg::StatusOk},
    '{"2147483647+1", 1'b0, 0,  1'b1, 32'h80000000, asp_pkg::StatusOk},
    '{" - -(1 +2) ",  1'b0, 0,  1'b0, 32'd0,        asp_pkg::StatusOk},
    '{"(1)2",         1'b0, 0,  1'b0, 32'd0,        asp_pkg::StatusOk},
    '{"1 2-)3",       1'b0, 0,  1'b0, 32'd0,        asp_pkg::StatusOk},
    '{"((5",          1'b0, 0,  1'b1, 32'd5,        asp_pkg::StatusUnbalanced},
    '{"1#)",          1'b0, 0,  1'b1, 32'd1,        asp_pkg::StatusInvalid},
    '{"\377 7",       1'b1, 0,  1'b1, 32'd7,        asp_pkg::StatusInvalid},
    '{"9",            1'b0, 33, 1'b1, 32'd9,        asp_pkg::StatusOverflow},
    '{"-(-(3)) - 8",  1'b0, 0,  1'b0, 32'd0,        asp_pkg::StatusOk},
    '{"+-+7 -",       1'b0, 0,  1'b0, 32'd0,        asp_pkg::StatusOk}
  };

  // predictor state
  logic [31:0]      num_acc;
  logic [31:0]      level_sum;
  logic             sign_neg;
  int unsigned      nest;
  logic [31:0]      frame_sum [FrameDepth];
  logic             frame_neg [FrameDepth];
  asp_pkg::status_e first_err;
  int unsigned      deepest;

  expr_result_t expected_results [$];
  pin_t         pinned_results [$];
  logic [7:0]   expr_chars [$];

  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned burst_left;
  bit          held_long;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void clear_expr_state();
    num_acc   = '0;
    level_sum = '0;
    sign_neg  = 1'b0;
    nest      = 0;
    first_err = asp_pkg::StatusOk;
  endfunction

  function automatic void note_err(asp_pkg::status_e e);
    if (first_err == asp_pkg::StatusOk) first_err = e;
  endfunction

  function automatic void fold_num();
    level_sum = sign_neg ? level_sum - num_acc : level_sum + num_acc;
    num_acc   = '0;
  endfunction

  function automatic bit eval_char(input logic [7:0] c, input logic l, output expr_result_t r);
    r = '0;
    if (c >= asp_pkg::CharZero && c <= asp_pkg::CharNine) begin
      num_acc = num_acc * 32'd10 + 32'(c - asp_pkg::CharZero);
    end else if (c == asp_pkg::CharPlus || c == asp_pkg::CharMinus) begin
      fold_num();
      sign_neg = (c == asp_pkg::CharMinus);
    end else if (c == asp_pkg::CharLParen) begin
      if (nest < FrameDepth) begin
        frame_sum[nest] = level_sum;
        frame_neg[nest] = sign_neg;
        nest++;
        if (nest > deepest) deepest = nest;
        level_sum = '0;
        num_acc   = '0;
        sign_neg  = 1'b0;
      end else begin
        note_err(asp_pkg::StatusOverflow);
      end
    end else if (c == asp_pkg::CharRParen) begin
      fold_num();
      if (nest > 0) begin
        nest--;
        level_sum = frame_neg[nest] ? frame_sum[nest] - level_sum
                                    : frame_sum[nest] + level_sum;
      end else begin
        note_err(asp_pkg::StatusUnbalanced);
      end
      sign_neg = 1'b0;
    end else if (c != asp_pkg::CharSpace) begin
      note_err(asp_pkg::StatusInvalid);
    end
    if (!l) return 1'b0;
    fold_num();
    if (nest != 0) note_err(asp_pkg::StatusUnbalanced);
    r.value  = level_sum;
    r.status = first_err;
    clear_expr_state();
    return 1'b1;
  endfunction

  initial clear_expr_state();

  always @(posedge clk_i) begin
    expr_result_t r;
    pin_t p;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (eval_char(character_i, last_i, r)) begin
        p = pinned_results.pop_front();
        expected_results.push_back(p.on ? p.r : r);
      end
    end
  end

  always @(posedge clk_i) begin
    expr_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %0d status %0d", value_o, status_o);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        results_checked++;
        if (value_o !== e.value) begin
          $error("value: expected %0d, got %0d", $signed(e.value), value_o);
          mismatches++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned seg;
    int unsigned mode;
    int unsigned dens;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_long && items_sent > 300) begin
        held_long = 1'b1;
        repeat (400) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      seg  = $urandom_range(10, 80);
      mode = $urandom_range(0, 9);
      dens = $urandom_range(1, 3);
      for (int unsigned k = 0; k < seg; k++) begin
        case (mode)
          0, 1, 2: out_stall_i <= 1'b0;
          8:       out_stall_i <= k[0];
          9:       out_stall_i <= (k < seg / 2);
          default: out_stall_i <= ($urandom_range(0, 3) < dens);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic l);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    character_i <= c;
    last_i      <= l;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_expr(input bit pin_on, input expr_result_t pin_r);
    pin_t p;
    int unsigned n;
    if (expr_chars.size() == 0) expr_chars.push_back(asp_pkg::CharSpace);
    n    = expr_chars.size();
    p.on = pin_on;
    p.r  = pin_r;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == n - 1) pinned_results.push_back(p);
      send_char(expr_chars[k], k == n - 1);
    end
    expr_chars.delete();
  endtask

  function automatic void add_spaces();
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 2)) expr_chars.push_back(asp_pkg::CharSpace);
  endfunction

  function automatic void add_number();
    int unsigned ndig;
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    for (int unsigned k = 0; k < ndig; k++) begin
      expr_chars.push_back(asp_pkg::CharZero + 8'($urandom_range(0, 9)));
      if (k + 1 < ndig && $urandom_range(0, 15) == 0) expr_chars.push_back(asp_pkg::CharSpace);
    end
  endfunction

  function automatic void add_ops(input bit must);
    int unsigned nops;
    nops = must ? $urandom_range(1, 3) : $urandom_range(0, 2);
    if (must && $urandom_range(0, 3) != 0) nops = 1;
    repeat (nops) begin
      expr_chars.push_back($urandom_range(0, 1) ? asp_pkg::CharMinus : asp_pkg::CharPlus);
      add_spaces();
    end
  endfunction

  function automatic void add_expr(input int unsigned lvl);
    int unsigned terms;
    terms = $urandom_range(1, 4);
    for (int unsigned k = 0; k < terms; k++) begin
      add_spaces();
      add_ops(k > 0);
      if (lvl < 6 && $urandom_range(0, 3) == 0) begin
        expr_chars.push_back(asp_pkg::CharLParen);
        add_expr(lvl + 1);
        expr_chars.push_back(asp_pkg::CharRParen);
        if ($urandom_range(0, 7) == 0) add_number();
      end else begin
        add_number();
      end
      add_spaces();
    end
  endfunction

  function automatic void add_deep();
    int unsigned n;
    int unsigned closes;
    n = $urandom_range(FrameDepth - 4, FrameDepth + 3);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        add_number();
        add_ops(1'b1);
      end else if ($urandom_range(0, 1) == 0) begin
        add_ops(1'b0);
      end
      expr_chars.push_back(asp_pkg::CharLParen);
    end
    add_expr(6);
    closes = $urandom_range(0, 3) == 0 ? $urandom_range(0, n + 1) : n;
    repeat (closes) begin
      expr_chars.push_back(asp_pkg::CharRParen);
      if ($urandom_range(0, 3) == 0) begin
        add_ops(1'b1);
        add_number();
      end
    end
  endfunction

  function automatic void add_noise();
    int unsigned len;
    logic [7:0] alphabet [15];
    alphabet = '{"0", "1", "5", "9", asp_pkg::CharPlus, asp_pkg::CharMinus,
                 asp_pkg::CharLParen, asp_pkg::CharRParen, asp_pkg::CharLParen,
                 asp_pkg::CharRParen, asp_pkg::CharSpace, "7", "3", "-", "("};
    len = $urandom_range(1, 12);
    repeat (len) begin
      if ($urandom_range(0, 2) == 0) expr_chars.push_back(8'($urandom_range(0, 255)));
      else expr_chars.push_back(alphabet[$urandom_range(0, 14)]);
    end
  endfunction

  function automatic void add_broken();
    int unsigned pos;
    add_expr(0);
    pos = $urandom_range(0, expr_chars.size() - 1);
    case ($urandom_range(0, 2))
      0: expr_chars.delete(pos);
      1: expr_chars.insert(pos, $urandom_range(0, 1) ? asp_pkg::CharRParen
                                                      : asp_pkg::CharLParen);
      default: expr_chars.insert(pos, 8'($urandom_range(0, 255)));
    endcase
  endfunction

  initial begin
    expr_result_t pin_r;
    int unsigned pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].lead_nul) expr_chars.push_back(8'h00);
      repeat (dir_rows[i].opens) expr_chars.push_back(asp_pkg::CharLParen);
      for (int k = 0; k < dir_rows[i].text.len(); k++) expr_chars.push_back(dir_rows[i].text[k]);
      pin_r.value  = dir_rows[i].value;
      pin_r.status = dir_rows[i].status;
      send_expr(dir_rows[i].pinned, pin_r);
    end

    pin_r = '0;
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) add_expr(0);
      else if (pick < 78) add_deep();
      else if (pick < 90) add_broken();
      else add_noise();
      send_expr(1'b0, pin_r);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end

    $display("Sent %0d characters forming %0d checked expressions in %0d cycles.",
             items_sent, results_checked, cycles);
    $display("Deepest nesting reached %0d; receiver held off for 400 cycles once.", deepest);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
